// ===== rtl/core/escape_sequence_decoder_core_defines.svh =====
// assertion macros for the escape sequence decoder core
// used by modules that have clk_i and rst_ni in scope
`ifndef ESCAPE_SEQUENCE_DECODER_CORE_DEFINES_SVH
`define ESCAPE_SEQUENCE_DECODER_CORE_DEFINES_SVH

// same cycle implication
`define ESD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next cycle implication
`define ESD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/esd_pkg.sv =====
// shared types and constants for the escape sequence decoder core
// no dependencies
package esd_pkg;

  localparam int unsigned CodeW      = 12;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    logic             two;
    logic [CodeW-1:0] code1;
    logic [CodeW-1:0] code0;
  } entry_t;

endpackage

// ===== rtl/core/escape_sequence_decoder_core.sv =====
// escape sequence decoder core: byte in, decoded character codes out
// a result reaches the master side through the entry queue and then the output register
// throughput: one byte per cycle while the entry queue is not full; a byte giving two results
// needs two output transfers, absorbed by the entry queue between decoder and output stage
// reset: asynchronous, active low; clears the escape state, the queue and the output stage
// depends on esd_pkg, esd_front, esd_fifo, esd_back
module escape_sequence_decoder_core #(
  parameter int unsigned QueueDepth = esd_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // text_byte
  input  logic        s_axis_tlast_i,   // end_of_text
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // code [11:0], zero fill
  output logic        m_axis_tlast_o    // last_of_run
);

  logic                      accept, push, pop, full, empty;
  esd_pkg::entry_t           wentry, rentry;
  logic [esd_pkg::CodeW-1:0] code;

  assign s_axis_tready_o = !full;
  assign accept          = s_axis_tvalid_i && !full;

  esd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata_i),
    .end_i    (s_axis_tlast_i),
    .push_o   (push),
    .entry_o  (wentry)
  );

  esd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wentry),
    .pop_i   (pop),
    .rdata_o (rentry),
    .full_o  (full),
    .empty_o (empty)
  );

  esd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .entry_i     (rentry),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_code_o  (code),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {{(16-esd_pkg::CodeW){1'b0}}, code};

endmodule

// ===== rtl/core/esd_front.sv =====
// front part: holds the escape state, decodes each byte into queue entries
// depends on esd_pkg
module esd_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [esd_pkg::ByteW-1:0]  byte_i,
  input  logic                       end_i,
  output logic                       push_o,
  output esd_pkg::entry_t            entry_o
);

  typedef enum logic [2:0] {
    ModeIdle  = 3'd0,
    ModeEsc   = 3'd1,
    ModeCaret = 3'd2,
    ModeHex   = 3'd3,
    ModeOct   = 3'd4
  } mode_e;

  localparam logic [7:0] Backslash = 8'h5C;
  localparam logic [7:0] Caret     = 8'h5E;
  localparam logic [7:0] LetterX   = 8'h58;
  localparam logic [7:0] CtrlBase  = 8'h40;
  localparam logic [7:0] EscCode   = 8'h1B;

  mode_e                     mode_q, mode_d;
  logic [esd_pkg::CodeW-1:0] val_q, val_d;
  logic [1:0]                cnt_q, cnt_d;

  logic [7:0]                up;
  logic                      is_dec, is_hexl, is_oct, is_hex, dig, hit;
  logic [7:0]                letter;
  logic [3:0]                hex_d;
  logic [esd_pkg::CodeW-1:0] shifted, b_ext;
  logic [1:0]                cnt_inc;
  logic                      emit;
  esd_pkg::entry_t           ent;

  assign up      = (byte_i >= 8'h61 && byte_i <= 8'h7A) ? byte_i - 8'h20 : byte_i;
  assign is_dec  = byte_i >= 8'h30 && byte_i <= 8'h39;
  assign is_hexl = up >= 8'h41 && up <= 8'h46;
  assign is_oct  = byte_i >= 8'h30 && byte_i <= 8'h37;
  assign is_hex  = is_dec || is_hexl;
  assign hex_d   = is_dec ? byte_i[3:0] : byte_i[3:0] + 4'd9;
  assign b_ext   = {{(esd_pkg::CodeW-8){1'b0}}, byte_i};
  assign cnt_inc = cnt_q + 2'd1;

  always_comb begin
    hit = 1'b1;
    case (up)
      8'h42:   letter = 8'h08;
      8'h46:   letter = 8'h0C;
      8'h4E:   letter = 8'h0A;
      8'h52:   letter = 8'h0D;
      8'h53:   letter = 8'h20;
      8'h54:   letter = 8'h09;
      8'h45:   letter = EscCode;
      default: begin
        letter = 8'h00;
        hit    = 1'b0;
      end
    endcase
  end

  always_comb begin
    dig     = (mode_q == ModeHex) ? is_hex : is_oct;
    shifted = (mode_q == ModeHex) ? {val_q[esd_pkg::CodeW-5:0], hex_d}
                                  : {val_q[esd_pkg::CodeW-4:0], byte_i[2:0]};
  end

  always_comb begin
    mode_d = mode_q;
    val_d  = val_q;
    cnt_d  = cnt_q;
    emit   = 1'b0;
    ent    = '0;
    if (end_i) begin
      mode_d = ModeIdle;
      val_d  = '0;
      cnt_d  = '0;
      case (mode_q)
        ModeEsc: begin
          emit      = 1'b1;
          ent.code0 = {{(esd_pkg::CodeW-8){1'b0}}, Backslash};
        end
        ModeCaret: begin
          emit      = 1'b1;
          ent.code0 = {{(esd_pkg::CodeW-8){1'b0}}, 8'h00 - CtrlBase};
        end
        ModeHex, ModeOct: begin
          emit      = 1'b1;
          ent.code0 = val_q;
        end
        default: ;
      endcase
    end else begin
      case (mode_q)
        ModeEsc: begin
          if (hit) begin
            emit      = 1'b1;
            ent.code0 = {{(esd_pkg::CodeW-8){1'b0}}, letter};
            mode_d    = ModeIdle;
            val_d     = '0;
            cnt_d     = '0;
          end else if (up == Caret) begin
            mode_d = ModeCaret;
          end else if (up == LetterX) begin
            mode_d = ModeHex;
            val_d  = '0;
            cnt_d  = '0;
          end else if (is_oct) begin
            mode_d = ModeOct;
            val_d  = {{(esd_pkg::CodeW-3){1'b0}}, byte_i[2:0]};
            cnt_d  = 2'd1;
          end else begin
            emit      = 1'b1;
            ent.code0 = b_ext;
            mode_d    = ModeIdle;
            val_d     = '0;
            cnt_d     = '0;
          end
        end
        ModeCaret: begin
          emit      = 1'b1;
          ent.code0 = {{(esd_pkg::CodeW-8){1'b0}}, up - CtrlBase};
          mode_d    = ModeIdle;
          val_d     = '0;
          cnt_d     = '0;
        end
        ModeHex, ModeOct: begin
          if (dig) begin
            val_d = shifted;
            cnt_d = cnt_inc;
            if (cnt_inc == 2'd3) begin
              emit      = 1'b1;
              ent.code0 = shifted;
              mode_d    = ModeIdle;
              val_d     = '0;
              cnt_d     = '0;
            end
          end else begin
            emit      = 1'b1;
            ent.code0 = val_q;
            val_d     = '0;
            cnt_d     = '0;
            if (byte_i == Backslash) begin
              mode_d = ModeEsc;
            end else begin
              mode_d    = ModeIdle;
              ent.two   = 1'b1;
              ent.code1 = b_ext;
            end
          end
        end
        default: begin
          val_d = '0;
          cnt_d = '0;
          if (byte_i == Backslash) begin
            mode_d = ModeEsc;
          end else begin
            mode_d    = ModeIdle;
            emit      = 1'b1;
            ent.code0 = b_ext;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      val_q  <= '0;
      cnt_q  <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      val_q  <= val_d;
      cnt_q  <= cnt_d;
    end
  end

  assign push_o  = accept_i && emit;
  assign entry_o = ent;

endmodule

// ===== rtl/core/esd_fifo.sv =====
// small queue of decoded entries between front and back
// depends on esd_pkg and the defines header
`include "escape_sequence_decoder_core_defines.svh"
module esd_fifo #(
  parameter int unsigned Depth = esd_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  esd_pkg::entry_t wdata_i,
  input  logic            pop_i,
  output esd_pkg::entry_t rdata_o,
  output logic            full_o,
  output logic            empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  esd_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `ESD_ASSERT_IMP(a_no_push_full, push_i, !full_o)
  `ESD_ASSERT_IMP(a_no_pop_empty, pop_i, !empty_o)

endmodule

// ===== rtl/core/esd_back.sv =====
// back part: drains queue entries into one result item per cycle while the master side accepts
// depends on esd_pkg and the defines header
`include "escape_sequence_decoder_core_defines.svh"
module esd_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      empty_i,
  input  esd_pkg::entry_t           entry_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [esd_pkg::CodeW-1:0] out_code_o,
  output logic                      out_last_o
);

  logic                      out_valid_q;
  logic [esd_pkg::CodeW-1:0] out_code_q;
  logic                      out_last_q;
  logic                      pend_q;
  logic [esd_pkg::CodeW-1:0] pend_code_q;
  logic                      slot_free;

  assign slot_free = !out_valid_q || out_ready_i;
  assign pop_o     = slot_free && !pend_q && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else if (slot_free) begin
      if (pend_q) begin
        out_valid_q <= 1'b1;
        pend_q      <= 1'b0;
      end else begin
        out_valid_q <= !empty_i;
        pend_q      <= !empty_i && entry_i.two;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free) begin
      if (pend_q) begin
        out_code_q <= pend_code_q;
        out_last_q <= 1'b1;
      end else begin
        out_code_q  <= entry_i.code0;
        out_last_q  <= !entry_i.two;
        pend_code_q <= entry_i.code1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_code_o  = out_code_q;
  assign out_last_o  = out_last_q;

  `ESD_ASSERT_IMP(a_pend_has_first, pend_q, out_valid_q && !out_last_q)
  `ESD_ASSERT_IMP(a_no_pop_while_pend, pend_q, !pop_o)
  `ESD_ASSERT_NXT(a_second_follows, pend_q && out_ready_i, out_valid_q && out_last_q)

endmodule

// ===== tb/tb_escape_sequence_decoder_core.sv =====
// self-checking testbench for escape_sequence_decoder_core: directed and random text streams,
// predicted codes compared in order against the master side under random idling and stalls
// depends on esd_pkg and the escape_sequence_decoder_core rtl
module tb_escape_sequence_decoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_CARET     = "^";
  localparam logic [7:0] CTRL_BASE    = 8'h40;
  localparam logic [7:0] CODE_BS      = 8'h08;
  localparam logic [7:0] CODE_FF      = 8'h0C;
  localparam logic [7:0] CODE_LF      = 8'h0A;
  localparam logic [7:0] CODE_CR      = 8'h0D;
  localparam logic [7:0] CODE_SPACE   = 8'h20;
  localparam logic [7:0] CODE_TAB     = 8'h09;
  localparam logic [7:0] CODE_ESC     = 8'h1B;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_ESC,
    MODE_CARET,
    MODE_HEX,
    MODE_OCT
  } decode_mode_e;

  typedef struct packed {
    logic [esd_pkg::CodeW-1:0] code;
    logic                      last;
  } decoded_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;   // text_byte
  logic        s_axis_tlast_i = 1'b0; // end_of_text
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;        // code [11:0], zero fill
  logic        m_axis_tlast_o;        // last_of_run

  decoded_t     expected_codes[$];
  decode_mode_e dec_mode  = MODE_IDLE;
  logic [11:0]  dec_value = '0;
  logic [1:0]   dec_count = '0;

  int unsigned items_sent   = 0;
  int unsigned fail_count   = 0;
  int unsigned hold_cycles  = 0;
  bit          tx_gaps_on   = 1'b1;
  bit          rx_gaps_on   = 1'b1;

  escape_sequence_decoder_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [7:0] upcase(logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'h20 : c;
  endfunction

  task automatic clear_decoder();
    dec_mode  = MODE_IDLE;
    dec_value = '0;
    dec_count = '0;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eot);
    logic [11:0] codes[$];
    logic [7:0]  u;
    logic [3:0]  digit;
    bit          is_digit;
    decoded_t    r;
    u = upcase(b);
    digit = '0;
    is_digit = 1'b0;
    if (eot) begin
      case (dec_mode)
        MODE_ESC:           codes.push_back(12'(CH_BACKSLASH));
        MODE_CARET:         codes.push_back(12'(8'(8'h00 - CTRL_BASE)));
        MODE_HEX, MODE_OCT: codes.push_back(dec_value);
        default: ;
      endcase
      clear_decoder();
    end else begin
      case (dec_mode)
        MODE_ESC: begin
          clear_decoder();
          case (u)
            "B": codes.push_back(12'(CODE_BS));
            "F": codes.push_back(12'(CODE_FF));
            "N": codes.push_back(12'(CODE_LF));
            "R": codes.push_back(12'(CODE_CR));
            "S": codes.push_back(12'(CODE_SPACE));
            "T": codes.push_back(12'(CODE_TAB));
            "E": codes.push_back(12'(CODE_ESC));
            CH_CARET: dec_mode = MODE_CARET;
            "X": dec_mode = MODE_HEX;
            default: begin
              if (b >= "0" && b <= "7") begin
                dec_mode  = MODE_OCT;
                dec_value = 12'(b - "0");
                dec_count = 2'd1;
              end else begin
                codes.push_back(12'(b));
              end
            end
          endcase
        end
        MODE_CARET: begin
          codes.push_back(12'(8'(u - CTRL_BASE)));
          clear_decoder();
        end
        MODE_HEX, MODE_OCT: begin
          if (dec_mode == MODE_HEX) begin
            if (b >= "0" && b <= "9") begin
              is_digit = 1'b1;
              digit = 4'(b - "0");
            end else if (u >= "A" && u <= "F") begin
              is_digit = 1'b1;
              digit = 4'(u - "A" + 8'd10);
            end
          end else if (b >= "0" && b <= "7") begin
            is_digit = 1'b1;
            digit = 4'(b - "0");
          end
          if (is_digit) begin
            dec_value = (dec_mode == MODE_HEX) ? {dec_value[7:0], digit}
                                               : {dec_value[8:0], digit[2:0]};
            dec_count = dec_count + 2'd1;
            if (dec_count == 2'd3) begin
              codes.push_back(dec_value);
              clear_decoder();
            end
          end else begin
            // run ended early: value first, then the byte as in idle
            codes.push_back(dec_value);
            clear_decoder();
            if (b == CH_BACKSLASH) dec_mode = MODE_ESC;
            else codes.push_back(12'(b));
          end
        end
        default: begin
          clear_decoder();
          if (b == CH_BACKSLASH) dec_mode = MODE_ESC;
          else codes.push_back(12'(b));
        end
      endcase
    end
    foreach (codes[i]) begin
      r.code = codes[i];
      r.last = (i == codes.size() - 1);
      expected_codes.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic send_item(input logic [7:0] b, input logic eot);
    @(negedge clk_i);
    while (tx_gaps_on && $urandom_range(99) < 25) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= eot;
    do @(posedge clk_i); while (!s_axis_tready_o);
    decode_byte(b, eot);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_item(s[i], 1'b0);
  endtask

  task automatic wait_all_codes();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (expected_codes.size() != 0) @(posedge clk_i);
  endtask

  // receiver: random idling, plus a long hold-off when requested
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      m_axis_tready_i <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      m_axis_tready_i <= !(rx_gaps_on && $urandom_range(99) < 25);
    end
  end

  always @(posedge clk_i) begin
    decoded_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_codes.size() == 0) begin
        report_mismatch("unexpected item", m_axis_tdata_o, 16'h0);
      end else begin
        want = expected_codes.pop_front();
        if (m_axis_tdata_o !== {4'h0, want.code})
          report_mismatch("code", m_axis_tdata_o, {4'h0, want.code});
        if (m_axis_tlast_o !== want.last)
          report_mismatch("last_of_run", 16'(m_axis_tlast_o), 16'(want.last));
      end
    end
  end

  function automatic logic [7:0] random_hex_char();
    string hex_chars;
    hex_chars = "0123456789abcdefABCDEF";
    return hex_chars[$urandom_range(0, 21)];
  endfunction

  function automatic logic [7:0] random_letter();
    string letters;
    logic [7:0] c;
    letters = "bfnrtse";
    c = letters[$urandom_range(0, 6)];
    return $urandom_range(1) ? c - 8'h20 : c;
  endfunction

  task automatic send_run_end();
    case ($urandom_range(0, 3))
      0: send_item(CH_BACKSLASH, 1'b0);
      1: send_item(8'($urandom_range(0, 255)), 1'b0);
      2: send_item(8'($urandom_range(0, 255)), 1'b1);
      default: ;
    endcase
  endtask

  task automatic send_random_sequence();
    int unsigned n;
    case ($urandom_range(0, 11))
      0, 1, 2: send_item(8'($urandom_range(0, 255)), 1'b0);
      3, 4: begin
        send_item(CH_BACKSLASH, 1'b0);
        send_item(random_letter(), 1'b0);
      end
      5: begin
        send_item(CH_BACKSLASH, 1'b0);
        send_item(CH_CARET, 1'b0);
        send_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end
      6, 7: begin
        n = $urandom_range(0, 3);
        send_item(CH_BACKSLASH, 1'b0);
        send_item($urandom_range(1) ? "x" : "X", 1'b0);
        repeat (n) send_item(random_hex_char(), 1'b0);
        if (n < 3) send_run_end();
      end
      8, 9: begin
        n = $urandom_range(1, 3);
        send_item(CH_BACKSLASH, 1'b0);
        repeat (n) send_item(8'("0" + $urandom_range(0, 7)), 1'b0);
        if (n < 3) send_run_end();
      end
      10: begin
        send_item(CH_BACKSLASH, 1'b0);
        send_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end
      default: send_item(8'($urandom_range(0, 255)), 1'b1);
    endcase
  endtask

  task automatic send_random_items(input int unsigned count);
    int unsigned first;
    first = items_sent;
    while (items_sent - first < count) send_random_sequence();
  endtask

  task automatic test_plain_and_letters();
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_text("\\n\\E");
  endtask

  task automatic test_caret();
    send_text("\\^a");
    send_text("\\^");
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_digit_runs();
    send_text("\\xfF9");
    send_text("\\xg");
    send_text("\\12\\");
    send_item(8'hFF, 1'b1);
  endtask

  task automatic test_random_traffic();
    send_random_items(650);
  endtask

  task automatic test_no_idling();
    wait_all_codes();
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    send_random_items(200);
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  task automatic test_output_stall();
    wait_all_codes();
    @(posedge clk_i);
    hold_cycles = 150;
    tx_gaps_on = 1'b0;
    send_random_items(60);
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    send_random_items(40);
    wait_all_codes();
    send_random_items(40);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_plain_and_letters();
    test_caret();
    test_digit_runs();
    test_random_traffic();
    test_no_idling();
    test_output_stall();
    test_drain_pause();
    wait_all_codes();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
